// ===== hw/rtl/worker_gang_pool_allocator_unit_defines.svh =====
// Assertion helpers shared by the allocator RTL.
`ifndef WORKER_GANG_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define WORKER_GANG_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WKGP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wkgp same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WKGP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wkgp next-cycle check failed");

`endif

// ===== hw/rtl/wkgp_pkg.sv =====
`default_nettype none

package wkgp_pkg;

	// Slot indices are at most 6 bits; links carry one more bit for the null mark.
	typedef logic [5:0] slot_t;
	typedef logic [6:0] link_t;
	typedef logic [6:0] count_t;

	localparam link_t LINK_NULL = 7'h7F;

	localparam logic OP_ASSIGN  = 1'b0;
	localparam logic OP_RECLAIM = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK              = 2'd0,
		STATUS_ASSIGN_REFUSED  = 2'd1,
		STATUS_RECLAIM_REFUSED = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE         = 4'b0001,
		ST_ASSIGN_CHECK = 4'b0010,
		ST_ASSIGN_EMIT  = 4'b0100,
		ST_RECLAIM_WALK = 4'b1000
	} state_t;

	// Control bundle from the sequencer to the link store.
	typedef struct packed {
		slot_t rd_addr;
		logic  wr_en;
		slot_t wr_addr;
		link_t wr_data;
		logic  clear;
	} link_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wkgp_link_mem.sv =====
`default_nettype none

module wkgp_link_mem #(
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire wkgp_pkg::link_req_t req,
	output wkgp_pkg::link_t          link
);
	import wkgp_pkg::*;

	localparam int IDX_W   = $clog2(DEPTH);
	localparam int ENTRIES = 1 << IDX_W;

	link_t              mem [ENTRIES];
	logic [ENTRIES-1:0] vld_q;
	link_t              data_s1;
	logic               vld_s1;
	slot_t              addr_s1;

	// An entry not written since the last rebuild links to the slot after it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clear) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.wr_addr[IDX_W-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[IDX_W-1:0]] <= req.wr_data;
		end
		data_s1 <= mem[req.rd_addr[IDX_W-1:0]];
		vld_s1  <= vld_q[req.rd_addr[IDX_W-1:0]];
		addr_s1 <= req.rd_addr;
	end

	assign link = vld_s1 ? data_s1 : ({1'b0, addr_s1} + 7'd1);

endmodule

`default_nettype wire

// ===== hw/rtl/worker_gang_pool_allocator_unit.sv =====
`default_nettype none

// Worker gang pool allocator.
// A request is presented on operation, count and group_head and is taken at a
// rising edge where start is high and busy is low. An assign request hands out
// count free worker slots, one result per slot in free-list order, the final
// one marked by last. A reclaim request walks the chain starting at group_head,
// checks that it holds exactly count slots and pushes it back on the free list;
// it gives a single result. Refusals give one result with a non-zero status.
// Each result is shown for exactly one cycle with done high; the receiver has
// no means to hold it off, so it must take every result as it comes.
// Timing: a refusal found at once appears in the cycle after the request. An
// accepted assign walks the free list twice (a checking walk, then the
// emitting walk), its first result following the checking walk; a reclaim
// walks its chain once. The chain is followed one link per
// cycle through the registered read port of the link memory, which sets rate.
// The pool_size register is written through cfg_valid/cfg_ready while the block
// is idle; a write rebuilds the free list at once, as reset does, with no
// clearing pass: the rebuilt list lives in per-slot valid flags.
module worker_gang_pool_allocator_unit #(
	parameter int POOL_DEPTH = 64
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire                operation,
	input  wire  [6:0]         count,
	input  wire  [5:0]         group_head,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [6:0]         pool_size,
	output logic               done,
	output logic [1:0]         status,
	output logic [5:0]         worker_slot,
	output logic [6:0]         idle_left,
	output logic               last
);
	import wkgp_pkg::*;

`include "worker_gang_pool_allocator_unit_defines.svh"

	// At most 64 slots are addressable, whatever the depth.
	localparam int MAX_SLOTS = (POOL_DEPTH < 64) ? POOL_DEPTH : 64;
	localparam count_t MAX_SLOTS_C = count_t'(MAX_SLOTS);

	state_t    state_q, state_d;
	count_t    pool_q, pool_d;
	link_t     head_q, head_d;
	count_t    idle_q, idle_d;
	link_t     cur_q, cur_d;
	count_t    k_q, k_d;
	count_t    cnt_q, cnt_d;
	slot_t     gh_q, gh_d;

	logic      done_q, done_d;
	status_t   status_q, status_d;
	slot_t     slot_q, slot_d;
	count_t    left_q, left_d;
	logic      last_q, last_d;

	link_req_t req;
	link_t     link;
	link_t     nxt_link;
	logic      nxt_null;
	logic      cur_valid;
	logic      k_last;
	logic      cfg_fire;
	logic      start_fire;
	logic [7:0] rec_sum;
	count_t    sat_size;

	wkgp_link_mem #(
		.DEPTH(MAX_SLOTS)
	) u_link_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.link  (link)
	);

	// The link memory is always reading the slot that cur_q takes next, so the
	// link of the current slot is ready in the cycle that cur_q holds it.
	assign cur_valid = cur_q < pool_q;
	assign nxt_null  = !(cur_valid && (link < pool_q));
	assign nxt_link  = nxt_null ? LINK_NULL : link;
	assign k_last    = (k_q + 7'd1) == cnt_q;

	assign busy       = (state_q != ST_IDLE);
	assign cfg_ready  = (state_q == ST_IDLE) && !start;
	assign cfg_fire   = cfg_valid && cfg_ready;
	assign start_fire = start && !busy;
	assign rec_sum    = {1'b0, idle_q} + {1'b0, count};

	// A written size is clamped into the usable range.
	always_comb begin
		if (pool_size == 7'd0) begin
			sat_size = 7'd1;
		end else if (pool_size > MAX_SLOTS_C) begin
			sat_size = MAX_SLOTS_C;
		end else begin
			sat_size = pool_size;
		end
	end

	always_comb begin
		state_d  = state_q;
		pool_d   = pool_q;
		head_d   = head_q;
		idle_d   = idle_q;
		cur_d    = cur_q;
		k_d      = k_q;
		cnt_d    = cnt_q;
		gh_d     = gh_q;
		done_d   = 1'b0;
		status_d = STATUS_OK;
		slot_d   = '0;
		left_d   = idle_q;
		last_d   = 1'b1;
		req.wr_en   = 1'b0;
		req.wr_addr = cur_q[5:0];
		req.wr_data = LINK_NULL;
		req.clear   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (cfg_fire) begin
					pool_d    = sat_size;
					idle_d    = sat_size;
					head_d    = '0;
					req.clear = 1'b1;
				end else if (start_fire) begin
					cnt_d = count;
					gh_d  = group_head;
					k_d   = '0;
					if (operation == OP_ASSIGN) begin
						if (count == 7'd0 || count > idle_q) begin
							done_d   = 1'b1;
							status_d = STATUS_ASSIGN_REFUSED;
						end else begin
							cur_d   = head_q;
							state_d = ST_ASSIGN_CHECK;
						end
					end else begin
						if (count == 7'd0 || {1'b0, group_head} >= pool_q ||
						    rec_sum > {1'b0, pool_q}) begin
							done_d   = 1'b1;
							status_d = STATUS_RECLAIM_REFUSED;
						end else begin
							cur_d   = {1'b0, group_head};
							state_d = ST_RECLAIM_WALK;
						end
					end
				end
			end
			ST_ASSIGN_CHECK: begin
				// The list must reach count slots before anything is handed out.
				if (!cur_valid) begin
					done_d   = 1'b1;
					status_d = STATUS_ASSIGN_REFUSED;
					state_d  = ST_IDLE;
				end else if (k_last) begin
					cur_d   = head_q;
					k_d     = '0;
					idle_d  = idle_q - cnt_q;
					state_d = ST_ASSIGN_EMIT;
				end else begin
					cur_d = nxt_link;
					k_d   = k_q + 7'd1;
				end
			end
			ST_ASSIGN_EMIT: begin
				done_d = 1'b1;
				slot_d = cur_q[5:0];
				last_d = k_last;
				if (k_last) begin
					// Cut the chain at its tail and move the head past it.
					head_d    = nxt_link;
					req.wr_en = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					cur_d = nxt_link;
					k_d   = k_q + 7'd1;
				end
			end
			ST_RECLAIM_WALK: begin
				if (!k_last) begin
					if (nxt_null) begin
						done_d   = 1'b1;
						status_d = STATUS_RECLAIM_REFUSED;
						state_d  = ST_IDLE;
					end else begin
						cur_d = nxt_link;
						k_d   = k_q + 7'd1;
					end
				end else if (!nxt_null) begin
					done_d   = 1'b1;
					status_d = STATUS_RECLAIM_REFUSED;
					state_d  = ST_IDLE;
				end else begin
					// Splice the returned chain in front of the free list.
					req.wr_en   = 1'b1;
					req.wr_data = (head_q < pool_q) ? head_q : LINK_NULL;
					head_d      = {1'b0, gh_q};
					idle_d      = idle_q + cnt_q;
					left_d      = idle_q + cnt_q;
					done_d      = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		req.rd_addr = cur_d[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pool_q  <= MAX_SLOTS_C;
			idle_q  <= MAX_SLOTS_C;
			head_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pool_q  <= pool_d;
			idle_q  <= idle_d;
			head_q  <= head_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q    <= cur_d;
		k_q      <= k_d;
		cnt_q    <= cnt_d;
		gh_q     <= gh_d;
		status_q <= status_d;
		slot_q   <= slot_d;
		left_q   <= left_d;
		last_q   <= last_d;
	end

	assign done        = done_q;
	assign status      = status_q;
	assign worker_slot = slot_q;
	assign idle_left   = left_q;
	assign last        = last_q;

	// An assignment's results come back to back until the one marked last.
	`WKGP_ASSERT_NEXT(a_emit_unbroken, clk, arst_n, done_q && !last_q, done_q)
	// The idle count never exceeds the pool in use.
	`WKGP_ASSERT_IMPLIES(a_idle_bound, clk, arst_n, 1'b1, idle_q <= pool_q)
	// A refusal is always a single closing result without a slot.
	`WKGP_ASSERT_IMPLIES(a_refusal_shape, clk, arst_n, done_q && status_q != STATUS_OK,
		last_q && slot_q == 6'd0)

endmodule

`default_nettype wire
